[rtl/aie_pkg.sv]
// ============================================================================
// aie_pkg
// Shared constants, types and helper functions for the accumulator
// instruction executor: operation and display codes, the decoded
// instruction record and the result record.
// ============================================================================
package aie_pkg;

   // Sizing of the data memory and of a data word.
   localparam int MEM_WORDS   = 256;
   localparam int DATA_BITS   = 32;
   localparam int ADDR_BITS   = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

   // Instruction queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Beat widths on the ports.
   localparam int REQ_DATA_BITS = 64;
   localparam int REQ_USER_BITS = 7;
   localparam int RSP_DATA_BITS = 72;
   localparam int RSP_USER_BITS = 1;

   // Operation codes.
   localparam logic [3:0] OP_SET   = 4'd0;
   localparam logic [3:0] OP_LDR   = 4'd1;
   localparam logic [3:0] OP_ADD   = 4'd2;
   localparam logic [3:0] OP_INC   = 4'd3;
   localparam logic [3:0] OP_DEC   = 4'd4;
   localparam logic [3:0] OP_STR   = 4'd5;
   localparam logic [3:0] OP_SHW   = 4'd6;
   localparam logic [3:0] OP_PAUSE = 4'd7;
   localparam logic [3:0] OP_END   = 4'd8;

   // Display targets of SHW.
   localparam logic [2:0] SHOW_ACC    = 3'd0;
   localparam logic [2:0] SHOW_MAR    = 3'd1;
   localparam logic [2:0] SHOW_MDR    = 3'd2;
   localparam logic [2:0] SHOW_STATUS = 3'd3;
   localparam logic [2:0] SHOW_MEM    = 3'd4;
   localparam logic [2:0] SHOW_NULL   = 3'd5;

   // Operand counts of ADD.
   localparam logic [1:0] ADD_NONE  = 2'd0;
   localparam logic [1:0] ADD_ONE   = 2'd1;
   localparam logic [1:0] ADD_TWO   = 2'd2;
   localparam logic [1:0] ADD_THREE = 2'd3;

   // Decoded instruction as it sits in the queue.
   typedef struct packed {
      logic [3:0]           op_code;
      logic [1:0]           add_count;
      logic [2:0]           show_target;
      logic [7:0]           addr1;
      logic [7:0]           addr3;
      logic [ADDR_BITS-1:0] idx1;
      logic [ADDR_BITS-1:0] idx2;
      logic [ADDR_BITS-1:0] idx3;
      logic [DATA_BITS-1:0] imm;
   } instr_type;

   // One result beat.
   typedef struct packed {
      logic        show_valid;
      logic [31:0] show_value;
      logic [31:0] acc_value;
      logic        running;
      logic        pause_request;
   } result_type;

   // Reduce an 8-bit address to a memory index by restoring subtraction.
   function automatic logic [ADDR_BITS-1:0] mem_index(input logic [7:0] addr);
      logic [23:0] rem;
      logic [23:0] step;
      rem = 24'(addr);
      for (int i = 7; i >= 0; i--) begin
         step = 24'(MEM_WORDS) << i;
         if (rem >= step) begin
            rem = rem - step;
         end
      end
      return ADDR_BITS'(rem);
   endfunction

   // Sign-extend or truncate a 32-bit input value to a data word.
   function automatic logic [DATA_BITS-1:0] word_in(input logic [31:0] x);
      logic [63:0] wide;
      wide = 64'(signed'(x));
      return wide[DATA_BITS-1:0];
   endfunction

   // Sign-extend or truncate a data word to a 32-bit output value.
   function automatic logic [31:0] word_out(input logic [DATA_BITS-1:0] w);
      logic [63:0] wide;
      wide = 64'(signed'(w));
      return wide[31:0];
   endfunction

endpackage

[rtl/aie_ram.sv]
// ============================================================================
// aie_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module aie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/aie_front.sv]
// ============================================================================
// aie_front
// Front end: accepts instruction beats, decodes them into a compact record
// with reduced memory indexes, and holds them in a short queue for the back.
// ============================================================================
module aie_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [aie_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   input  logic [aie_pkg::REQ_USER_BITS-1:0]     req_tuser,
   input  logic                                  pop,
   output logic                                  head_valid,
   output aie_pkg::instr_type                    head
);
   import aie_pkg::*;

   instr_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   instr_type             decoded;
   logic                  push;
   logic                  take;

   // Decode the incoming beat.
   always_comb begin
      decoded.op_code     = req_tuser[3:0];
      decoded.show_target = req_tuser[6:4];
      decoded.addr1       = req_tdata[7:0];
      decoded.addr3       = req_tdata[23:16];
      decoded.add_count   = req_tdata[25:24];
      decoded.imm         = word_in(req_tdata[57:26]);
      decoded.idx1        = mem_index(req_tdata[7:0]);
      decoded.idx2        = mem_index(req_tdata[15:8]);
      decoded.idx3        = mem_index(req_tdata[23:16]);
   end

   assign req_tready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != '0);
   assign take       = pop && head_valid;
   assign head       = entry_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

[rtl/aie_back.sv]
// ============================================================================
// aie_back
// Back end: takes one decoded instruction from the queue, reads its memory
// operands at issue, then computes, writes the memory, updates the machine
// registers and loads the result register once that register is free.
// ============================================================================
module aie_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  aie_pkg::instr_type     head,
   output logic                   pop,
   output logic                   res_valid,
   input  logic                   res_ready,
   output aie_pkg::result_type    res
);
   import aie_pkg::*;

   logic                  busy_ff, busy_in;
   instr_type             ins_ff;
   logic [DATA_BITS-1:0]  acc_ff, acc_in;
   logic [7:0]            mar_ff, mar_in;
   logic [DATA_BITS-1:0]  mdr_ff, mdr_in;
   logic                  run_ff, run_in;
   logic [MEM_WORDS-1:0]  mem_valid_ff;
   logic                  res_valid_ff, res_valid_in;
   result_type            res_ff, res_in;

   logic [ADDR_BITS-1:0]  rd_idx1, rd_idx2;
   logic [DATA_BITS-1:0]  ram1_q, ram2_q;
   logic [DATA_BITS-1:0]  mem1, mem2;
   logic                  finish;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_idx;
   logic [DATA_BITS-1:0]  wr_data;
   logic [DATA_BITS-1:0]  sum;
   logic                  show_valid;
   logic [31:0]           show_value;
   logic                  pause;

   // Issue and completion control: one instruction at a time; a new one issues only when idle.
   assign pop    = !busy_ff && head_valid;
   assign finish = busy_ff && (!res_valid_ff || res_ready);
   assign busy_in = pop ? 1'b1 : (finish ? 1'b0 : busy_ff);

   // Read addresses come from the queue head at issue and are held after.
   assign rd_idx1 = busy_ff ? ins_ff.idx1 : head.idx1;
   assign rd_idx2 = busy_ff ? ins_ff.idx2 : head.idx2;

   // Two copies of the data memory give two read ports.
   aie_ram #(.WIDTH(DATA_BITS), .DEPTH(MEM_WORDS)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_addr (rd_idx1),
      .rd_data (ram1_q)
   );

   aie_ram #(.WIDTH(DATA_BITS), .DEPTH(MEM_WORDS)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_addr (rd_idx2),
      .rd_data (ram2_q)
   );

   // Words never written since reset read as zero.
   assign mem1 = mem_valid_ff[ins_ff.idx1] ? ram1_q : '0;
   assign mem2 = mem_valid_ff[ins_ff.idx2] ? ram2_q : '0;
   assign sum  = mem1 + mem2;

   // Execute the instruction held in the back.
   always_comb begin
      acc_in     = acc_ff;
      mar_in     = mar_ff;
      mdr_in     = mdr_ff;
      run_in     = run_ff;
      wr_en      = 1'b0;
      wr_idx     = ins_ff.idx1;
      wr_data    = ins_ff.imm;
      show_valid = 1'b0;
      show_value = '0;
      pause      = 1'b0;
      case (ins_ff.op_code)
         OP_SET: begin
            mar_in  = ins_ff.addr1;
            mdr_in  = ins_ff.imm;
            wr_en   = 1'b1;
         end
         OP_LDR: begin
            mar_in = ins_ff.addr1;
            mdr_in = mem1;
            acc_in = mem1;
         end
         OP_ADD: begin
            case (ins_ff.add_count)
               ADD_ONE: begin
                  acc_in = acc_ff + mem1;
               end
               ADD_TWO: begin
                  acc_in = sum;
               end
               ADD_THREE: begin
                  acc_in  = sum;
                  mar_in  = ins_ff.addr3;
                  mdr_in  = sum;
                  wr_en   = 1'b1;
                  wr_idx  = ins_ff.idx3;
                  wr_data = sum;
               end
               default: begin
               end
            endcase
         end
         OP_INC, OP_DEC: begin
            wr_data = (ins_ff.op_code == OP_INC) ? mem1 + 1'b1 : mem1 - 1'b1;
            acc_in  = wr_data;
            mar_in  = ins_ff.addr1;
            mdr_in  = wr_data;
            wr_en   = 1'b1;
         end
         OP_STR: begin
            mar_in  = ins_ff.addr1;
            mdr_in  = acc_ff;
            wr_en   = 1'b1;
            wr_data = acc_ff;
         end
         OP_SHW: begin
            case (ins_ff.show_target)
               SHOW_ACC: begin
                  show_valid = 1'b1;
                  show_value = word_out(acc_ff);
               end
               SHOW_MAR: begin
                  show_valid = 1'b1;
                  show_value = 32'(mar_ff);
               end
               SHOW_MDR: begin
                  show_valid = 1'b1;
                  show_value = word_out(mdr_ff);
               end
               SHOW_STATUS: begin
                  show_valid = 1'b1;
                  show_value = 32'(run_ff);
               end
               SHOW_MEM: begin
                  show_valid = 1'b1;
                  show_value = word_out(mem1);
                  mar_in     = ins_ff.addr1;
                  mdr_in     = mem1;
               end
               default: begin
               end
            endcase
         end
         OP_PAUSE: begin
            pause = 1'b1;
         end
         OP_END: begin
            run_in = 1'b0;
         end
         default: begin
         end
      endcase
      wr_en = wr_en && finish;
   end

   // Result beat built from the state after the instruction.
   always_comb begin
      res_in.show_valid    = show_valid;
      res_in.show_value    = show_value;
      res_in.acc_value     = word_out(acc_in);
      res_in.running       = run_in;
      res_in.pause_request = pause;
      res_valid_in = finish ? 1'b1 : (res_ready ? 1'b0 : res_valid_ff);
   end

   // Control and machine registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         res_valid_ff <= 1'b0;
         acc_ff       <= '0;
         mar_ff       <= '0;
         mdr_ff       <= '0;
         run_ff       <= 1'b1;
         mem_valid_ff <= '0;
      end else begin
         busy_ff      <= busy_in;
         res_valid_ff <= res_valid_in;
         if (finish) begin
            acc_ff <= acc_in;
            mar_ff <= mar_in;
            mdr_ff <= mdr_in;
            run_ff <= run_in;
         end
         if (wr_en) begin
            mem_valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         ins_ff <= head;
      end
      if (finish) begin
         res_ff <= res_in;
      end
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

endmodule

[rtl/accumulator_instruction_executor.sv]
// ============================================================================
// accumulator_instruction_executor
// Executes decoded instructions of a small accumulator machine with a data
// memory, an accumulator, an address register and a data register, and
// returns one result beat per instruction.
// ============================================================================
//
//   Channel   Direction  Handshake              Carries
//   req_      in         req_tvalid/req_tready  one decoded instruction
//   rsp_      out        rsp_tvalid/rsp_tready  display, accumulator, status
//
// Each instruction passes through the execute stage in two steps: it reads the
// operands from the data memory copies, then computes and writes back. The
// single memory write port and its read-after-write order call for this split.
// A two-entry queue lets new beats in while the result register is held.
// Reset is synchronous; memory words read as zero until first written.
//
module accumulator_instruction_executor (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] first_address, [15:8] second_address, [23:16] third_address,
   // [25:24] add_operand_count, [57:26] immediate_value, [63:58] zero
   input  logic [aie_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // [3:0] operation, [6:4] show_target
   input  logic [aie_pkg::REQ_USER_BITS-1:0]     req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] show_value, [63:32] accumulator_value, [64] running,
   // [65] pause_request, [71:66] zero
   output logic [aie_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // [0] show_valid
   output logic [aie_pkg::RSP_USER_BITS-1:0]     rsp_tuser
);
   import aie_pkg::*;

   instr_type  head;
   logic       head_valid;
   logic       pop;
   result_type res;

   // Front end with the instruction queue.
   aie_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Execute stage with data memory and result register.
   aie_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .res_valid  (rsp_tvalid),
      .res_ready  (rsp_tready),
      .res        (res)
   );

   // Pack the result beat.
   assign rsp_tdata = {6'b0, res.pause_request, res.running, res.acc_value, res.show_value};
   assign rsp_tuser = res.show_valid;

endmodule

[rtl/aie_checker.sv]
// ============================================================================
// aie_checker
// Port-level checks on the result channel of the accumulator instruction
// executor, attached to the top level by a bind statement.
// ============================================================================
module aie_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [aie_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic [aie_pkg::RSP_USER_BITS-1:0]  rsp_tuser
);
   import aie_pkg::*;

   // No result beat is offered in the cycle after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat offered straight after reset");

   // A stalled result beat holds its contents.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // Without a display the shown value is zero.
   a_no_show_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[31:0] == 32'd0)
      else $error("shown value not zero without display");

   // A pause beat never carries a display.
   a_pause_no_show: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[65] |-> !rsp_tuser[0])
      else $error("pause beat carries a display");

endmodule

bind accumulator_instruction_executor aie_checker u_aie_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[tb/accumulator_instruction_executor_tb.sv]
// ============================================================================
// accumulator_instruction_executor_tb
// Self-checking testbench for the accumulator instruction executor. Drives
// decoded instructions on the request stream and compares every result beat,
// field by field, against a shadow copy of the machine's memory and
// registers. It runs directed corner cases, random traffic with idle and
// stall bursts, a drain pause, back-to-back traffic and execution after END.
// ============================================================================
module accumulator_instruction_executor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import aie_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 20;

   // Codes outside the defined operations and display targets.
   localparam logic [3:0] OP_UNUSED_LOW  = 4'd9;
   localparam logic [3:0] OP_UNUSED_HIGH = 4'd15;
   localparam logic [2:0] SHOW_UNUSED    = 3'd7;

   // One decoded instruction as the testbench sees it.
   typedef struct packed {
      logic [3:0]  op;
      logic [7:0]  a1;
      logic [7:0]  a2;
      logic [7:0]  a3;
      logic [1:0]  cnt;
      logic [31:0] imm;
      logic [2:0]  tgt;
   } instruction_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [REQ_USER_BITS-1:0] req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b1;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [RSP_USER_BITS-1:0] rsp_tuser;

   // Shadow state of the machine.
   logic [DATA_BITS-1:0] shadow_mem [MEM_WORDS];
   logic [DATA_BITS-1:0] shadow_acc;
   logic [7:0]           shadow_mar;
   logic [DATA_BITS-1:0] shadow_mdr;
   logic                 shadow_running;

   result_type expected_results [$];

   bit sender_idles    = 1'b0;
   bit receiver_stalls = 1'b0;
   int mismatch_count  = 0;
   int beats_checked   = 0;
   int instrs_sent     = 0;
   int quiet_cycles    = 0;

   accumulator_instruction_executor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Widen or narrow a data word to the 32-bit output, keeping its sign.
   function automatic logic [31:0] as_output(input logic [DATA_BITS-1:0] w);
      return 32'($signed(w));
   endfunction

   function automatic instruction_type make_instr(input logic [3:0] op, input logic [7:0] a1,
                                                  input logic [7:0] a2, input logic [7:0] a3,
                                                  input logic [1:0] cnt, input logic [31:0] imm,
                                                  input logic [2:0] tgt);
      instruction_type ins;
      ins = '{op: op, a1: a1, a2: a2, a3: a3, cnt: cnt, imm: imm, tgt: tgt};
      return ins;
   endfunction

   // Executes one instruction on the shadow state and returns its result.
   function automatic result_type execute_instruction(input instruction_type ins);
      result_type           res;
      logic [DATA_BITS-1:0] word;
      int                   idx1;
      int                   idx2;
      int                   idx3;
      res  = '0;
      idx1 = int'(ins.a1) % MEM_WORDS;
      idx2 = int'(ins.a2) % MEM_WORDS;
      idx3 = int'(ins.a3) % MEM_WORDS;
      case (ins.op)
         OP_SET: begin
            word             = DATA_BITS'($signed(ins.imm));
            shadow_mar       = ins.a1;
            shadow_mdr       = word;
            shadow_mem[idx1] = word;
         end
         OP_LDR: begin
            word       = shadow_mem[idx1];
            shadow_mar = ins.a1;
            shadow_mdr = word;
            shadow_acc = word;
         end
         OP_ADD: begin
            if (ins.cnt == ADD_ONE) begin
               shadow_acc = shadow_acc + shadow_mem[idx1];
            end else if (ins.cnt == ADD_TWO || ins.cnt == ADD_THREE) begin
               word       = shadow_mem[idx1] + shadow_mem[idx2];
               shadow_acc = word;
               if (ins.cnt == ADD_THREE) begin
                  shadow_mar       = ins.a3;
                  shadow_mdr       = word;
                  shadow_mem[idx3] = word;
               end
            end
         end
         OP_INC, OP_DEC: begin
            word             = (ins.op == OP_INC) ? shadow_mem[idx1] + 1'b1
                                                  : shadow_mem[idx1] - 1'b1;
            shadow_acc       = word;
            shadow_mar       = ins.a1;
            shadow_mdr       = word;
            shadow_mem[idx1] = word;
         end
         OP_STR: begin
            shadow_mar       = ins.a1;
            shadow_mdr       = shadow_acc;
            shadow_mem[idx1] = shadow_acc;
         end
         OP_SHW: begin
            case (ins.tgt)
               SHOW_ACC: begin
                  res.show_valid = 1'b1;
                  res.show_value = as_output(shadow_acc);
               end
               SHOW_MAR: begin
                  res.show_valid = 1'b1;
                  res.show_value = 32'(shadow_mar);
               end
               SHOW_MDR: begin
                  res.show_valid = 1'b1;
                  res.show_value = as_output(shadow_mdr);
               end
               SHOW_STATUS: begin
                  res.show_valid = 1'b1;
                  res.show_value = 32'(shadow_running);
               end
               SHOW_MEM: begin
                  word           = shadow_mem[idx1];
                  shadow_mar     = ins.a1;
                  shadow_mdr     = word;
                  res.show_valid = 1'b1;
                  res.show_value = as_output(word);
               end
               default: begin
               end
            endcase
         end
         OP_PAUSE: res.pause_request = 1'b1;
         OP_END:   shadow_running = 1'b0;
         default: begin
         end
      endcase
      res.acc_value = as_output(shadow_acc);
      res.running   = shadow_running;
      return res;
   endfunction

   // Drives one instruction beat, with an optional idle burst before it, and
   // records its expected result once the beat is accepted.
   task automatic send_instr(input instruction_type ins);
      int gap;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, ins.imm, ins.cnt, ins.a3, ins.a2, ins.a1};
      req_tuser  <= {ins.tgt, ins.op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(execute_instruction(ins));
      instrs_sent++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Random instruction, biased towards a few hot addresses so that words
   // are read back after being written.
   function automatic instruction_type random_instruction(input bit allow_end);
      instruction_type ins;
      int              pick;
      ins  = '0;
      pick = $urandom_range(0, 99);
      if      (pick < 15) ins.op = OP_SET;
      else if (pick < 27) ins.op = OP_LDR;
      else if (pick < 47) ins.op = OP_ADD;
      else if (pick < 55) ins.op = OP_INC;
      else if (pick < 63) ins.op = OP_DEC;
      else if (pick < 71) ins.op = OP_STR;
      else if (pick < 88) ins.op = OP_SHW;
      else if (pick < 93) ins.op = OP_PAUSE;
      else if (pick < 95 && allow_end) ins.op = OP_END;
      else ins.op = 4'($urandom_range(int'(OP_UNUSED_LOW), int'(OP_UNUSED_HIGH)));
      ins.a1  = ($urandom_range(0, 3) != 0) ? {$urandom_range(0, 1) ? 4'hF : 4'h0,
                                               4'($urandom)} : 8'($urandom);
      ins.a2  = ($urandom_range(0, 3) != 0) ? {4'h0, 4'($urandom)} : 8'($urandom);
      ins.a3  = ($urandom_range(0, 3) != 0) ? {4'hF, 4'($urandom)} : 8'($urandom);
      ins.cnt = 2'($urandom);
      ins.tgt = 3'($urandom);
      case ($urandom_range(0, 7))
         0:       ins.imm = 32'h7FFF_FFFF;
         1:       ins.imm = 32'h8000_0000;
         2:       ins.imm = 32'hFFFF_FFFF;
         3:       ins.imm = 32'($urandom_range(0, 3));
         default: ins.imm = $urandom;
      endcase
      return ins;
   endfunction

   // Extreme values, every operation but END, and the wrap, display and unknown cases.
   task automatic test_directed_cases();
      send_instr(make_instr(OP_SET, 8'd0,   8'd0, 8'd0, ADD_NONE, 32'h7FFF_FFFF, SHOW_ACC));
      send_instr(make_instr(OP_SET, 8'd255, 8'd0, 8'd0, ADD_NONE, 32'h8000_0000, SHOW_ACC));
      send_instr(make_instr(OP_SET, 8'd1,   8'd0, 8'd0, ADD_NONE, 32'hFFFF_FFFF, SHOW_ACC));
      send_instr(make_instr(OP_SET, 8'd2,   8'd0, 8'd0, ADD_NONE, 32'h0000_0001, SHOW_ACC));
      send_instr(make_instr(OP_LDR, 8'd0,   8'd0, 8'd0, ADD_NONE, 32'h0, SHOW_ACC));
      // Accumulator wraps from the largest positive to the most negative.
      send_instr(make_instr(OP_ADD, 8'd2,   8'd0, 8'd0, ADD_ONE,   32'h0, SHOW_ACC));
      send_instr(make_instr(OP_ADD, 8'd255, 8'd1, 8'd0, ADD_TWO,   32'h0, SHOW_ACC));
      send_instr(make_instr(OP_ADD, 8'd1,   8'd1, 8'd255, ADD_THREE, 32'h0, SHOW_MDR));
      send_instr(make_instr(OP_ADD, 8'd255, 8'd255, 8'd255, ADD_NONE, 32'hFFFF_FFFF,
                            SHOW_ACC));
      send_instr(make_instr(OP_INC, 8'd1,   8'd0, 8'd0, ADD_NONE, 32'h0, SHOW_ACC));
      send_instr(make_instr(OP_DEC, 8'd4,   8'd0, 8'd0, ADD_NONE, 32'h0, SHOW_ACC));
      send_instr(make_instr(OP_DEC, 8'd255, 8'd0, 8'd0, ADD_NONE, 32'h0, SHOW_ACC));
      send_instr(make_instr(OP_INC, 8'd0,   8'd0, 8'd0, ADD_NONE, 32'h0, SHOW_ACC));
      send_instr(make_instr(OP_STR, 8'd200, 8'd0, 8'd0, ADD_NONE, 32'h0, SHOW_ACC));
      // Every display target, including the empty and unknown ones.
      for (int t = 0; t < 8; t++) begin
         send_instr(make_instr(OP_SHW, 8'd255, 8'd0, 8'd0, ADD_NONE, 32'h0, 3'(t)));
      end
      send_instr(make_instr(OP_PAUSE, 8'd0, 8'd0, 8'd0, ADD_NONE, 32'h0, SHOW_ACC));
      send_instr(make_instr(OP_UNUSED_LOW, 8'd7, 8'd7, 8'd7, ADD_THREE, 32'h1234_5678,
                            SHOW_MEM));
      send_instr(make_instr(OP_UNUSED_HIGH, 8'd255, 8'd255, 8'd255, ADD_THREE, 32'hFFFF_FFFF,
                            SHOW_UNUSED));
   endtask

   task automatic test_random_traffic(input int count);
      for (int i = 0; i < count; i++) begin
         send_instr(random_instruction(1'b0));
      end
   endtask

   // The sender holds off until every outstanding result has come back.
   task automatic test_drain_pause();
      wait_for_drain();
      send_instr(make_instr(OP_SHW, 8'd0, 8'd0, 8'd0, ADD_NONE, 32'h0, SHOW_STATUS));
   endtask

   // END clears the running flag for good; later instructions still execute.
   task automatic test_after_end();
      send_instr(make_instr(OP_END, 8'd0, 8'd0, 8'd0, ADD_NONE, 32'h0, SHOW_ACC));
      send_instr(make_instr(OP_SHW, 8'd0, 8'd0, 8'd0, ADD_NONE, 32'h0, SHOW_STATUS));
      for (int i = 0; i < 30; i++) begin
         send_instr(random_instruction(1'b1));
      end
      send_instr(make_instr(OP_END, 8'd0, 8'd0, 8'd0, ADD_NONE, 32'h0, SHOW_ACC));
      send_instr(make_instr(OP_SHW, 8'd0, 8'd0, 8'd0, ADD_NONE, 32'h0, SHOW_STATUS));
   endtask

   // Receiver side: random stall bursts while enabled, ready otherwise.
   initial begin
      forever begin
         @(negedge clock);
         if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compares each accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("Result beat arrived with no instruction outstanding: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            exp_res = expected_results.pop_front();
            beats_checked++;
            if (rsp_tuser[0] !== exp_res.show_valid) begin
               $error("show_valid: expected %0d, got %0d", exp_res.show_valid, rsp_tuser[0]);
               mismatch_count++;
            end
            if (rsp_tdata[31:0] !== exp_res.show_value) begin
               $error("show_value: expected %h, got %h", exp_res.show_value, rsp_tdata[31:0]);
               mismatch_count++;
            end
            if (rsp_tdata[63:32] !== exp_res.acc_value) begin
               $error("accumulator_value: expected %h, got %h", exp_res.acc_value,
                      rsp_tdata[63:32]);
               mismatch_count++;
            end
            if (rsp_tdata[64] !== exp_res.running) begin
               $error("running: expected %0d, got %0d", exp_res.running, rsp_tdata[64]);
               mismatch_count++;
            end
            if (rsp_tdata[65] !== exp_res.pause_request) begin
               $error("pause_request: expected %0d, got %0d", exp_res.pause_request,
                      rsp_tdata[65]);
               mismatch_count++;
            end
            if (rsp_tdata[71:66] !== 6'b0) begin
               $error("padding: expected 0, got %h", rsp_tdata[71:66]);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: ends the run when neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      for (int i = 0; i < MEM_WORDS; i++) begin
         shadow_mem[i] = '0;
      end
      shadow_acc     = '0;
      shadow_mar     = '0;
      shadow_mdr     = '0;
      shadow_running = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      test_random_traffic(600);
      test_drain_pause();
      test_random_traffic(450);
      // Last part runs with both sides always ready.
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      test_random_traffic(300);
      test_after_end();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d result beats from %0d instructions: corner values, all operations,",
               beats_checked, instrs_sent);
      $display("random traffic with idle and stall bursts, a drain pause and work after END.");
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
